// ----- rtl/core/rqs_pkg.sv -----
package rqs_pkg;

  localparam int unsigned KEY_W  = 34;
  localparam int unsigned BILL_W = 32;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned CNT_W  = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Index of the sort-order register on the configuration port.
  localparam logic REG_SORT_ORDER = 1'b0;

  // One record as it enters the block.
  typedef struct packed {
    logic [KEY_W-1:0]  record_key;
    logic [BILL_W-1:0] bill_cents;
    logic              last_record;
  } in_item_t;

  // One sorted record as it leaves the block.
  typedef struct packed {
    logic [KEY_W-1:0]  sorted_key;
    logic [BILL_W-1:0] sorted_bill_cents;
    logic [POS_W-1:0]  load_position;
    logic [CNT_W-1:0]  compare_count;
    logic [CNT_W-1:0]  swap_count;
    logic              overflow_flag;
    logic              last_result;
  } out_item_t;

  // One entry of the record store.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [BILL_W-1:0] bill;
    logic [POS_W-1:0]  pos;
  } rec_t;

  // Saturating increment of an event counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
    sat_inc = (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
  endfunction

endpackage

// ----- rtl/core/record_quicksort_by_key.sv -----
// Record sorter. Records (key, bill in cents) arrive one transaction per cycle
// while in_stall_o is low and are stored with their load position; a record
// that arrives while MAX_ENTRIES are held is dropped and overflow_flag is
// raised for the run. The record carrying last_record starts a Lomuto
// quicksort by key (pivot is the last element of each range, right part first,
// ranges on an explicit stack), ascending or descending as the sort-order
// register says. The sort is not stable. Comparisons and swaps, self-swaps
// included, are counted and saturate at 4095. Then every stored record leaves
// in sorted order, each result carrying both counts, the last one marked by
// last_result. The sort uses one record memory and one key comparator: each
// partition pops a range, reads its pivot, compares each element, swaps each
// one that goes left of the pivot, puts the pivot in place and pushes the
// parts still to sort; each result is then read from the store and registered.
// in_stall_o stays high from the last record until the final result has been
// handed to the output register. The stores need no clearing after reset.
module record_quicksort_by_key import rqs_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Record input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,

  // Sorted record output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,

  // APB-style configuration port; register 0 at byte address 0.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic sort_desc_q;
  logic reg_idx;
  logic cfg_write;

  // The register index is the word address.
  assign reg_idx   = paddr[2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_desc_q <= 1'b0;
    end else if (cfg_write && reg_idx == REG_SORT_ORDER) begin
      sort_desc_q <= pwdata[0];
    end
  end

  // Reads of an address past the register list return zero.
  always_comb begin
    unique case (reg_idx)
      REG_SORT_ORDER: prdata = {31'b0, sort_desc_q};
      default:        prdata = '0;
    endcase
  end

  // Load, sort and read-out sequencer with its record and range stores.
  rqs_seq #(.MAX_ENTRIES(MAX_ENTRIES)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (sort_desc_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/core/rqs_ram.sv -----
module rqs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/rqs_cmp.sv -----
module rqs_cmp import rqs_pkg::*; (
  input  logic [KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0] pivot_i,
  input  logic             desc_i,
  output logic             goes_left_o
);

  // The key goes left of the pivot when it is strictly smaller (ascending)
  // or strictly larger (descending).
  logic lt, gt;

  assign lt          = key_i < pivot_i;
  assign gt          = key_i > pivot_i;
  assign goes_left_o = desc_i ? gt : lt;

endmodule

// ----- rtl/core/rqs_seq.sv -----
module rqs_seq import rqs_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      desc_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned IW         = $clog2(MAX_ENTRIES);
  localparam int unsigned CW         = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned STACK_SIZE = MAX_ENTRIES + 2;
  localparam int unsigned SAW        = $clog2(STACK_SIZE);
  localparam int unsigned TW         = $clog2(STACK_SIZE + 1);
  localparam int unsigned RW         = $bits(rec_t);

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_POP, S_POP_W, S_PIV, S_RDJ, S_CMP, S_SWP, S_SWP2,
    S_FIN, S_FIN2, S_FIN3, S_PUSH_L, S_PUSH_R, S_EMIT_RD, S_EMIT_WR
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            dropped_q, dropped_d;
  logic [CNT_W-1:0] cmp_cnt_q, cmp_cnt_d;
  logic [CNT_W-1:0] swp_cnt_q, swp_cnt_d;
  logic [TW-1:0]   top_q, top_d;
  logic [IW-1:0]   lo_q, lo_d, hi_q, hi_d, j_q, j_d, ip1_q, ip1_d, k_q, k_d;
  rec_t            pivot_q, pivot_d, hold_q, hold_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic            rec_we, rec_re;
  logic [IW-1:0]   rec_waddr, rec_raddr;
  rec_t            rec_wdata, rec_rdata;
  logic [RW-1:0]   rec_rdata_raw;

  logic            stk_we, stk_re;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [2*IW-1:0] stk_wdata, stk_rdata;

  logic            goes_left;
  logic            j_at_end;
  logic            k_at_end;
  logic            stk_room;
  logic [TW-1:0]   top_dec;

  rqs_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata_raw)
  );

  assign rec_rdata = rec_t'(rec_rdata_raw);

  rqs_ram #(.WIDTH(2*IW), .DEPTH(STACK_SIZE)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  rqs_cmp u_cmp (
    .key_i       (rec_rdata.key),
    .pivot_i     (pivot_q.key),
    .desc_i      (desc_i),
    .goes_left_o (goes_left)
  );

  assign j_at_end = ({1'b0, j_q} + (IW+1)'(1)) == {1'b0, hi_q};
  assign k_at_end = ((IW+1)'(k_q) + (IW+1)'(1)) == (IW+1)'(count_q);
  assign stk_room = top_q < TW'(STACK_SIZE);
  assign top_dec  = top_q - TW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    cmp_cnt_d   = cmp_cnt_q;
    swp_cnt_d   = swp_cnt_q;
    top_d       = top_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    j_d         = j_q;
    ip1_d       = ip1_q;
    k_d         = k_q;
    pivot_d     = pivot_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    rec_we      = 1'b0;
    rec_waddr   = j_q;
    rec_wdata   = hold_q;
    rec_re      = 1'b0;
    rec_raddr   = j_q;
    stk_we      = 1'b0;
    stk_waddr   = top_q[SAW-1:0];
    stk_wdata   = {lo_q, IW'(ip1_q - IW'(1))};
    stk_re      = 1'b0;
    stk_raddr   = top_dec[SAW-1:0];

    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (count_q < CW'(MAX_ENTRIES)) begin
            rec_we    = 1'b1;
            rec_waddr = IW'(count_q);
            rec_wdata = '{key:  in_item_i.record_key,
                          bill: in_item_i.bill_cents,
                          pos:  POS_W'(count_q)};
            count_d   = count_q + CW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_item_i.last_record) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmp_cnt_d = '0;
        swp_cnt_d = '0;
        top_d     = '0;
        if (count_q >= CW'(2)) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {IW'(0), IW'(count_q - CW'(1))};
          top_d     = TW'(1);
        end
        state_d = S_POP;
      end
      S_POP: begin
        if (top_q == '0) begin
          k_d     = '0;
          state_d = S_EMIT_RD;
        end else begin
          stk_re  = 1'b1;
          top_d   = top_dec;
          state_d = S_POP_W;
        end
      end
      S_POP_W: begin
        lo_d      = stk_rdata[2*IW-1:IW];
        hi_d      = stk_rdata[IW-1:0];
        rec_re    = 1'b1;
        rec_raddr = stk_rdata[IW-1:0];
        state_d   = S_PIV;
      end
      S_PIV: begin
        pivot_d = rec_rdata;
        j_d     = lo_q;
        ip1_d   = lo_q;
        state_d = S_RDJ;
      end
      S_RDJ: begin
        rec_re    = 1'b1;
        rec_raddr = j_q;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmp_cnt_d = sat_inc(cmp_cnt_q);
        if (goes_left) begin
          hold_d    = rec_rdata;
          rec_re    = 1'b1;
          rec_raddr = ip1_q;
          state_d   = S_SWP;
        end else if (j_at_end) begin
          state_d = S_FIN;
        end else begin
          // Nothing moves: fetch the next element and compare again.
          j_d       = j_q + IW'(1);
          rec_re    = 1'b1;
          rec_raddr = j_q + IW'(1);
        end
      end
      S_SWP: begin
        rec_we    = 1'b1;
        rec_waddr = ip1_q;
        rec_wdata = hold_q;
        hold_d    = rec_rdata;
        state_d   = S_SWP2;
      end
      S_SWP2: begin
        rec_we    = 1'b1;
        rec_waddr = j_q;
        rec_wdata = hold_q;
        swp_cnt_d = sat_inc(swp_cnt_q);
        ip1_d     = ip1_q + IW'(1);
        j_d       = j_q + IW'(1);
        state_d   = j_at_end ? S_FIN : S_RDJ;
      end
      S_FIN: begin
        rec_re    = 1'b1;
        rec_raddr = ip1_q;
        state_d   = S_FIN2;
      end
      S_FIN2: begin
        rec_we    = 1'b1;
        rec_waddr = ip1_q;
        rec_wdata = pivot_q;
        hold_d    = rec_rdata;
        state_d   = S_FIN3;
      end
      S_FIN3: begin
        rec_we    = 1'b1;
        rec_waddr = hi_q;
        rec_wdata = hold_q;
        swp_cnt_d = sat_inc(swp_cnt_q);
        state_d   = S_PUSH_L;
      end
      S_PUSH_L: begin
        if (({1'b0, lo_q} + (IW+1)'(1)) < {1'b0, ip1_q} && stk_room) begin
          stk_we    = 1'b1;
          stk_wdata = {lo_q, IW'(ip1_q - IW'(1))};
          top_d     = top_q + TW'(1);
        end
        state_d = S_PUSH_R;
      end
      S_PUSH_R: begin
        if (({1'b0, ip1_q} + (IW+1)'(1)) < {1'b0, hi_q} && stk_room) begin
          stk_we    = 1'b1;
          stk_wdata = {IW'(ip1_q + IW'(1)), hi_q};
          top_d     = top_q + TW'(1);
        end
        state_d = S_POP;
      end
      S_EMIT_RD: begin
        if (!out_valid_q || !out_stall_i) begin
          rec_re    = 1'b1;
          rec_raddr = k_q;
          state_d   = S_EMIT_WR;
        end
      end
      S_EMIT_WR: begin
        out_valid_d = 1'b1;
        out_d       = '{sorted_key:        rec_rdata.key,
                        sorted_bill_cents: rec_rdata.bill,
                        load_position:     rec_rdata.pos,
                        compare_count:     cmp_cnt_q,
                        swap_count:        swp_cnt_q,
                        overflow_flag:     dropped_q,
                        last_result:       k_at_end};
        k_d         = k_q + IW'(1);
        if (k_at_end) begin
          count_d   = '0;
          dropped_d = 1'b0;
          state_d   = S_LOAD;
        end else begin
          state_d = S_EMIT_RD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      cmp_cnt_q   <= '0;
      swp_cnt_q   <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      cmp_cnt_q   <= cmp_cnt_d;
      swp_cnt_q   <= swp_cnt_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    j_q     <= j_d;
    ip1_q   <= ip1_d;
    k_q     <= k_d;
    pivot_q <= pivot_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = state_q != S_LOAD;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/core/rqs_checker.sv -----
module rqs_checker import rqs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_item_t    in_item_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_item_o,
  input logic        pready
);

  // The record that closes a set makes the block busy for the sort.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.last_record |=> in_stall_o)
    else $error("input not stalled after last record");

  // No new records while a run is still being read out.
  a_stall_during_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_result |-> in_stall_o)
    else $error("input accepted during read-out");

  // A run without comparisons holds a single record and makes no swap.
  a_single_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.compare_count == '0 |->
      out_item_o.swap_count == '0 && out_item_o.last_result)
    else $error("counts inconsistent for single-record run");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind record_quicksort_by_key rqs_checker u_rqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .pready      (pready)
);

// ----- dv/record_quicksort_by_key_tb.sv -----
`timescale 1ns / 100ps

module record_quicksort_by_key_tb;
  import rqs_pkg::*;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned STACK_DEPTH = MAX_ENTRIES + 2;
  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 9;
  // Quiet cycles after the last result before the block counts as idle again.
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS = 320;
  localparam int PHASE_ITEMS = 80;
  localparam longint CYCLE_LIMIT = 1_000_000;

  // Key patterns for the random record sets.
  typedef enum int {
    KEYS_RANDOM,
    KEYS_CLUSTERED,
    KEYS_RISING,
    KEYS_FALLING
  } key_pattern_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  record_quicksort_by_key #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Cycle counter that the watchdog below compares against the limit.
  longint cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the record store of the block: records loaded
  // in the current set, the drop flag, the sort direction and the two event
  // totals of the latest sort.
  // ---------------------------------------------------------------------------
  rec_t             loaded_rec [MAX_ENTRIES];
  int unsigned      loaded_count = 0;
  bit               loaded_dropped = 1'b0;
  bit               desc_mode = 1'b0;
  logic [CNT_W-1:0] compare_total = '0;
  logic [CNT_W-1:0] swap_total = '0;
  int               range_lo_stk [STACK_DEPTH];
  int               range_hi_stk [STACK_DEPTH];
  int               range_top;

  // Sorted records that the block still owes us, oldest first.
  out_item_t        sorted_records_due [$];
  int unsigned      mismatch_count = 0;

  // Exchange two stored records; every exchange counts, self-swaps included.
  function automatic void swap_records(int a, int b);
    rec_t tmp;
    tmp = loaded_rec[a];
    loaded_rec[a] = loaded_rec[b];
    loaded_rec[b] = tmp;
    swap_total = sat_inc(swap_total);
  endfunction

  // Ranges of a single element are never stacked, and a full stack drops them.
  function automatic void push_range(int lo, int hi);
    if (lo < hi && range_top < STACK_DEPTH) begin
      range_lo_stk[range_top] = lo;
      range_hi_stk[range_top] = hi;
      range_top++;
    end
  endfunction

  // Lomuto quicksort over the loaded records, pivot at the top of each range.
  // The right part is pushed last, so it is partitioned first. Afterwards the
  // whole set is queued as expected results and the store starts over empty.
  function automatic void sort_loaded_records();
    int lo;
    int hi;
    int i;
    int j;
    logic [KEY_W-1:0] pivot;
    bit goes_left;
    out_item_t res;
    compare_total = '0;
    swap_total = '0;
    range_top = 0;
    push_range(0, int'(loaded_count) - 1);
    while (range_top > 0) begin
      range_top--;
      lo = range_lo_stk[range_top];
      hi = range_hi_stk[range_top];
      pivot = loaded_rec[hi].key;
      i = lo - 1;
      for (j = lo; j < hi; j++) begin
        compare_total = sat_inc(compare_total);
        goes_left = desc_mode ? (loaded_rec[j].key > pivot) : (loaded_rec[j].key < pivot);
        if (goes_left) begin
          i++;
          swap_records(i, j);
        end
      end
      swap_records(i + 1, hi);
      push_range(lo, i);
      push_range(i + 2, hi);
    end
    for (int k = 0; k < int'(loaded_count); k++) begin
      res.sorted_key        = loaded_rec[k].key;
      res.sorted_bill_cents = loaded_rec[k].bill;
      res.load_position     = loaded_rec[k].pos;
      res.compare_count     = compare_total;
      res.swap_count        = swap_total;
      res.overflow_flag     = loaded_dropped;
      res.last_result       = (k + 1 == int'(loaded_count));
      sorted_records_due.push_back(res);
    end
    loaded_count = 0;
    loaded_dropped = 1'b0;
  endfunction

  // A record accepted by the block: store it, or flag it as dropped when the
  // store is full. The record marked last starts the sort either way.
  function automatic void load_record(in_item_t rec);
    if (loaded_count < MAX_ENTRIES) begin
      loaded_rec[loaded_count] = '{key: rec.record_key, bill: rec.bill_cents,
                                   pos: POS_W'(loaded_count)};
      loaded_count++;
    end else begin
      loaded_dropped = 1'b1;
    end
    if (rec.last_record) begin
      sort_loaded_records();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Outputs are sampled at the rising edge, before any of the
  // nonblocking updates of that edge land, so the values seen are the ones the
  // block presented during the cycle that just ended.
  // ---------------------------------------------------------------------------
  out_item_t due_rec;

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (sorted_records_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected sorted record, expected none, actual %p", $time, out_item_o);
      end else begin
        due_rec = sorted_records_due.pop_front();
        check_field("sorted_key", 64'(due_rec.sorted_key), 64'(out_item_o.sorted_key));
        check_field("sorted_bill_cents", 64'(due_rec.sorted_bill_cents),
                    64'(out_item_o.sorted_bill_cents));
        check_field("load_position", 64'(due_rec.load_position),
                    64'(out_item_o.load_position));
        check_field("compare_count", 64'(due_rec.compare_count),
                    64'(out_item_o.compare_count));
        check_field("swap_count", 64'(due_rec.swap_count), 64'(out_item_o.swap_count));
        check_field("overflow_flag", 64'(due_rec.overflow_flag),
                    64'(out_item_o.overflow_flag));
        check_field("last_result", 64'(due_rec.last_result), 64'(out_item_o.last_result));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output back-pressure. Stall bursts appear only inside stretches where the
  // receiver is allowed to idle; other stretches run with the stall held low.
  // Clearing idling_allowed silences it for the final part.
  // ---------------------------------------------------------------------------
  bit idling_allowed = 1'b1;
  bit rx_idle_on = 1'b0;
  int rx_stretch_left = 0;
  int rx_stall_left = 0;
  bit tx_idle_on = 1'b0;

  always @(posedge clk_i) begin
    if (rx_stretch_left == 0) begin
      rx_stretch_left <= $urandom_range(20, 300);
      rx_idle_on <= ($urandom_range(0, 2) != 0);
    end else begin
      rx_stretch_left <= rx_stretch_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idling_allowed && rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_stall_left <= $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task returns right after a rising edge, so each
  // one can drive its signals with nonblocking assignments straight away.
  // ---------------------------------------------------------------------------

  // Present one record and hold it until the block takes the transaction.
  // Valid stays high on return so that a following record goes out back to
  // back, unless a sender gap follows, which may happen when idling is on.
  task automatic send_record(logic [KEY_W-1:0] key, logic [BILL_W-1:0] bill, bit last);
    in_item_t rec;
    rec = '{record_key: key, bill_cents: bill, last_record: last};
    in_valid_i <= 1'b1;
    in_item_i <= rec;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    load_record(rec);
    if (idling_allowed && tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every owed record has come back, then give the
  // block a few more cycles to settle before it is treated as idle.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (sorted_records_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the sort direction over the configuration port, then read it back.
  task automatic write_sort_order(bit descending);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SORT_ORDER, 2'b00};
    pwdata  <= 32'(descending);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    desc_mode = descending;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[0] !== descending) begin
      mismatch_count++;
      $display("%0t: sort order readback mismatch, expected %0d, actual 0x%0h",
               $time, descending, readback);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // A set of one record: nothing to compare, nothing to swap. The key and the
  // bill sit at the top of their field widths.
  task automatic test_single_record();
    send_record({KEY_W{1'b1}}, {BILL_W{1'b1}}, 1'b1);
    wait_results_drained();
  endtask

  // Field extremes in one ascending set, with a repeated key so that the
  // unstable ordering of equal keys is exercised as well.
  task automatic test_extreme_fields();
    send_record(34'd9999999999, 32'h0000_0000, 1'b0);
    send_record(34'd0, 32'hFFFF_FFFF, 1'b0);
    send_record({KEY_W{1'b1}}, 32'h5555_5555, 1'b0);
    send_record(34'd0, 32'hAAAA_AAAA, 1'b0);
    send_record(34'd1, 32'h0000_0001, 1'b1);
    wait_results_drained();
  endtask

  // Fill the store, then send one more record carrying the last marker. That
  // record is dropped, yet the sort must still start and flag the overflow.
  task automatic test_store_overflow();
    for (int k = 0; k < int'(MAX_ENTRIES); k++) begin
      send_record({2'($urandom), 32'($urandom)}, 32'($urandom), 1'b0);
    end
    send_record({2'($urandom), 32'($urandom)}, 32'($urandom), 1'b1);
    wait_results_drained();
  endtask

  // A short set in descending order, then back to ascending.
  task automatic test_descending_order();
    write_sort_order(1'b1);
    send_record(34'd17, 32'd100, 1'b0);
    send_record(34'd4242, 32'd200, 1'b1);
    wait_results_drained();
    write_sort_order(1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random sets. Sizes lean toward small sets, with full and overflowing sets
  // mixed in; key patterns cover wide random keys, heavy duplicates, and
  // already ordered input in both directions (the costly case for Lomuto).
  // ---------------------------------------------------------------------------
  task automatic send_random_set(ref int items_sent);
    int set_size;
    int size_pick;
    key_pattern_e pattern;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] key;
    size_pick = $urandom_range(0, 9);
    if (size_pick <= 5) begin
      set_size = $urandom_range(1, 6);
    end else if (size_pick <= 7) begin
      set_size = $urandom_range(7, MAX_ENTRIES);
    end else if (size_pick == 8) begin
      set_size = MAX_ENTRIES;
    end else begin
      set_size = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 3);
    end
    pattern = key_pattern_e'($urandom_range(0, 3));
    base = {2'($urandom), 32'($urandom)};
    tx_idle_on = ($urandom_range(0, 2) != 0);
    for (int k = 0; k < set_size; k++) begin
      case (pattern)
        KEYS_RANDOM: begin
          key = {2'($urandom), 32'($urandom)};
        end
        KEYS_CLUSTERED: begin
          key = base + KEY_W'($urandom_range(0, 3));
        end
        KEYS_RISING: begin
          key = base + KEY_W'(k);
        end
        default: begin
          key = base - KEY_W'(k);
        end
      endcase
      send_record(key, 32'($urandom), k == set_size - 1);
    end
    items_sent += set_size;
  endtask

  // Phases of about eighty records each, the sort direction rewritten between
  // phases while the block is idle. Now and then the sender also pauses until
  // every owed record is back. The final phase runs with no idling at all.
  task automatic test_random_sets();
    int items_sent;
    int phase_start;
    bit order;
    items_sent = 0;
    order = 1'($urandom_range(0, 1));
    while (items_sent < RANDOM_ITEMS) begin
      wait_results_drained();
      if (items_sent >= RANDOM_ITEMS - PHASE_ITEMS) begin
        idling_allowed = 1'b0;
      end
      write_sort_order(order);
      order = ~order;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < RANDOM_ITEMS) begin
        send_random_set(items_sent);
        if ($urandom_range(0, 5) == 0) begin
          wait_results_drained();
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_sort_order(1'b0);

    test_single_record();
    test_extreme_fields();
    test_store_overflow();
    test_descending_order();
    test_random_sets();

    // Everything is sent; wait for the last owed records plus a quiet tail in
    // which any extra result would still be caught by the checker.
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && sorted_records_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- record_quicksort_by_key.f -----
rtl/core/rqs_pkg.sv
rtl/core/rqs_ram.sv
rtl/core/rqs_cmp.sv
rtl/core/rqs_seq.sv
rtl/core/record_quicksort_by_key.sv
rtl/core/rqs_checker.sv
dv/record_quicksort_by_key_tb.sv
